// ===== hw/rtl/ocvm_pkg.sv =====
// ocvm_pkg: shared types, constants and helpers of the orbit camera view matrix
// used by the controller, the datapath and the top level; no dependencies
package ocvm_pkg;

  // trig values and matrix entries are Q4.30 in a 34-bit signed word
  localparam int TRIG_BITS = 30;
  localparam int TW        = 34;
  localparam int MW        = 34;
  localparam int PW        = 2 * MW;
  localparam int ACC_W     = PW + 2;
  localparam int SAT_W     = 72;

  localparam logic signed [TW-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLOAD_YAW,
    OP_CLOAD_PITCH,
    OP_CITER,
    OP_CSTORE_YAW,
    OP_CSTORE_PITCH,
    OP_MUL,
    OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    M_CYSP,
    M_SYSP,
    M_CYCP,
    M_SYCP,
    M_CYRAD,
    M_SYRAD,
    M_TX,
    M_TY,
    M_TZ
  } msel_e;

  typedef struct packed {
    logic       ready;
    logic       take;
    op_e        op;
    msel_e      msel;
    logic [1:0] row;
    logic [4:0] iter;
  } cmd_t;

  typedef struct packed {
    logic frame_valid;
    logic out_free;
  } status_t;

  // atan(2^-i) in degrees, Q.24, rounded to frac fraction bits
  function automatic logic [29:0] atan_fix(input logic [4:0] idx, input int frac);
    logic [29:0] tab;
    int          d;
    case (idx)
      5'd0:  tab = 30'd754974720;
      5'd1:  tab = 30'd445687602;
      5'd2:  tab = 30'd235489088;
      5'd3:  tab = 30'd119537938;
      5'd4:  tab = 30'd60000935;
      5'd5:  tab = 30'd30029717;
      5'd6:  tab = 30'd15018523;
      5'd7:  tab = 30'd7509720;
      5'd8:  tab = 30'd3754917;
      5'd9:  tab = 30'd1877466;
      5'd10: tab = 30'd938734;
      5'd11: tab = 30'd469367;
      5'd12: tab = 30'd234683;
      5'd13: tab = 30'd117342;
      5'd14: tab = 30'd58671;
      5'd15: tab = 30'd29335;
      5'd16: tab = 30'd14668;
      5'd17: tab = 30'd7334;
      5'd18: tab = 30'd3667;
      5'd19: tab = 30'd1833;
      5'd20: tab = 30'd917;
      5'd21: tab = 30'd458;
      5'd22: tab = 30'd229;
      5'd23: tab = 30'd115;
      default: tab = '0;
    endcase
    d = 24 - frac;
    if (d <= 0) begin
      return tab;
    end
    return (tab + ((30'd1 << d) >> 1)) >> d;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    if (v > SAT_W'(64'sd2147483647)) begin
      return 32'sh7fffffff;
    end
    if (v < -SAT_W'(64'sd2147483648)) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== hw/rtl/ocvm_frame_if.sv =====
// ocvm_frame_if: valid/ready channel carrying one frame item
// no dependencies
interface ocvm_frame_if;
  logic              valid;
  logic              ready;
  logic              move_valid;
  logic signed [1:0] move_x;
  logic signed [1:0] move_y;
  logic [15:0]       frame_time;

  modport source (output valid, move_valid, move_x, move_y, frame_time, input ready);
  modport sink   (input valid, move_valid, move_x, move_y, frame_time, output ready);
endinterface

// ===== hw/rtl/ocvm_row_if.sv =====
// ocvm_row_if: valid/ready channel carrying one view matrix row item
// no dependencies
interface ocvm_row_if;
  logic               valid;
  logic               ready;
  logic [1:0]         row_index;
  logic signed [31:0] entry_x;
  logic signed [31:0] entry_y;
  logic signed [31:0] entry_z;
  logic signed [31:0] entry_translation;
  logic               last_row;

  modport source (output valid, row_index, entry_x, entry_y, entry_z, entry_translation,
                  last_row, input ready);
  modport sink   (input valid, row_index, entry_x, entry_y, entry_z, entry_translation,
                  last_row, output ready);
endinterface

// ===== hw/rtl/ocvm_ctrl.sv =====
// ocvm_ctrl: sequencer that steps the datapath through one frame item
// depends on ocvm_pkg
module ocvm_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ocvm_pkg::status_t status_i,
  output ocvm_pkg::cmd_t    cmd_o
);

  localparam int CW = $clog2(CORDIC_STEPS);

  typedef enum logic [3:0] {
    S_IDLE, S_YLOAD, S_YITER, S_YSTORE, S_PLOAD, S_PITER, S_PSTORE,
    S_MUL, S_TERM, S_WAIT, S_EMIT
  } state_e;

  state_e         state_q;
  logic [CW-1:0]  cnt_q;
  logic [1:0]     row_q;

  always_comb begin
    cmd_o       = '0;
    cmd_o.op    = ocvm_pkg::OP_NOP;
    cmd_o.msel  = ocvm_pkg::M_CYSP;
    cmd_o.row   = row_q;
    cmd_o.iter  = 5'(cnt_q);
    cmd_o.ready = (state_q == S_IDLE);
    cmd_o.take  = (state_q == S_IDLE) && status_i.frame_valid;
    case (state_q)
      S_YLOAD:  cmd_o.op = ocvm_pkg::OP_CLOAD_YAW;
      S_PLOAD:  cmd_o.op = ocvm_pkg::OP_CLOAD_PITCH;
      S_YITER,
      S_PITER:  cmd_o.op = ocvm_pkg::OP_CITER;
      S_YSTORE: cmd_o.op = ocvm_pkg::OP_CSTORE_YAW;
      S_PSTORE: cmd_o.op = ocvm_pkg::OP_CSTORE_PITCH;
      S_MUL: begin
        cmd_o.op = ocvm_pkg::OP_MUL;
        case (cnt_q)
          CW'(0):  cmd_o.msel = ocvm_pkg::M_CYSP;
          CW'(1):  cmd_o.msel = ocvm_pkg::M_SYSP;
          CW'(2):  cmd_o.msel = ocvm_pkg::M_CYCP;
          CW'(3):  cmd_o.msel = ocvm_pkg::M_SYCP;
          CW'(4):  cmd_o.msel = ocvm_pkg::M_CYRAD;
          default: cmd_o.msel = ocvm_pkg::M_SYRAD;
        endcase
      end
      S_TERM: begin
        cmd_o.op = ocvm_pkg::OP_MUL;
        case (cnt_q)
          CW'(0):  cmd_o.msel = ocvm_pkg::M_TX;
          CW'(1):  cmd_o.msel = ocvm_pkg::M_TY;
          default: cmd_o.msel = ocvm_pkg::M_TZ;
        endcase
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.op = ocvm_pkg::OP_EMIT;
        end
      end
      default: cmd_o.op = ocvm_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      row_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (status_i.frame_valid) begin
            state_q <= S_YLOAD;
          end
        end
        S_YLOAD: begin
          cnt_q   <= '0;
          state_q <= S_YITER;
        end
        S_YITER: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(CORDIC_STEPS - 1)) begin
            state_q <= S_YSTORE;
          end
        end
        S_YSTORE: state_q <= S_PLOAD;
        S_PLOAD: begin
          cnt_q   <= '0;
          state_q <= S_PITER;
        end
        S_PITER: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(CORDIC_STEPS - 1)) begin
            state_q <= S_PSTORE;
          end
        end
        S_PSTORE: begin
          cnt_q   <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          if (cnt_q == CW'(5)) begin
            cnt_q   <= '0;
            row_q   <= '0;
            state_q <= S_TERM;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_TERM: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(2)) begin
            state_q <= S_WAIT;
          end
        end
        // last product lands in the accumulator here
        S_WAIT: state_q <= S_EMIT;
        S_EMIT: begin
          if (status_i.out_free) begin
            cnt_q <= '0;
            if (row_q == 2'd2) begin
              state_q <= S_IDLE;
            end else begin
              row_q   <= row_q + 2'd1;
              state_q <= S_TERM;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ocvm_datapath.sv =====
// ocvm_datapath: camera state, shared cordic, shared multiplier, accumulator
// and the output row register; depends on ocvm_pkg
module ocvm_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ocvm_pkg::cmd_t     cmd_i,
  output logic               out_free_o,
  input  logic               cfg_we_i,
  input  logic [30:0]        cfg_wdata_i,
  input  logic               move_valid_i,
  input  logic signed [1:0]  move_x_i,
  input  logic signed [1:0]  move_y_i,
  input  logic [15:0]        frame_time_i,
  input  logic               row_ready_i,
  output logic               row_valid_o,
  output logic [1:0]         row_index_o,
  output logic signed [31:0] entry_x_o,
  output logic signed [31:0] entry_y_o,
  output logic signed [31:0] entry_z_o,
  output logic signed [31:0] entry_translation_o,
  output logic               last_row_o
);

  localparam int TW    = ocvm_pkg::TW;
  localparam int MW    = ocvm_pkg::MW;
  localparam int PW    = ocvm_pkg::PW;
  localparam int ACC_W = ocvm_pkg::ACC_W;
  localparam int SAT_W = ocvm_pkg::SAT_W;
  localparam int AW    = FRAC_BITS + 10;
  localparam int ZW    = AW + 1;
  localparam int RW    = AW + 8;
  localparam int LSH   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int RSH   = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
  localparam int ESH   = ocvm_pkg::TRIG_BITS - FRAC_BITS;

  localparam logic signed [RW-1:0] D90   = RW'(longint'(90) << FRAC_BITS);
  localparam logic signed [RW-1:0] D180  = RW'(longint'(180) << FRAC_BITS);
  localparam logic signed [RW-1:0] D270  = RW'(longint'(270) << FRAC_BITS);
  localparam logic signed [RW-1:0] D360  = RW'(longint'(360) << FRAC_BITS);
  localparam logic signed [RW-1:0] RND16 = RW'((longint'(1) << RSH) >> 1);
  localparam logic signed [TW:0]   ERND  = (TW+1)'((longint'(1) << ESH) >> 1);
  localparam logic signed [PW-1:0] QRND  = PW'(longint'(1) << (ocvm_pkg::TRIG_BITS - 1));
  localparam logic signed [ACC_W-1:0] TRND =
    ACC_W'(longint'(1) << (ocvm_pkg::TRIG_BITS - 1));

  // camera state and config
  logic [30:0]            radius_q;
  logic signed [AW-1:0]   yaw_q, yaw_d;
  logic signed [AW-1:0]   pitch_q, pitch_d;
  logic signed [31:0]     height_q, height_d;

  // cordic
  logic signed [TW-1:0]   cdx_q, cdy_q;
  logic signed [ZW-1:0]   cdz_q;
  logic                   flip_q;
  logic signed [TW-1:0]   ycos_q, ysin_q, pcos_q, psin_q;
  logic                   pneg_q;

  // products
  logic signed [TW-1:0]   mcysp_q, msysp_q, mcycp_q, msycp_q, eye_x_q, eye_z_q;
  logic signed [PW-1:0]   prod_q;
  ocvm_pkg::msel_e        psel_q;
  logic                   pend_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                   row_valid_q;

  function automatic logic signed [RW-1:0] rescale16(input logic signed [RW-1:0] v);
    return ((v <<< LSH) + RND16) >>> RSH;
  endfunction

  function automatic logic signed [RW-1:0] wrap360(input logic signed [RW-1:0] v);
    if (v < 0) begin
      return v + D360;
    end
    if (v >= D360) begin
      return v - D360;
    end
    return v;
  endfunction

  // movement update
  logic signed [RW-1:0] mydt, yaw_t, pitch_t;
  logic signed [33:0]   height_t;
  always_comb begin
    case (move_y_i)
      2'sd1:   mydt = RW'($signed({1'b0, frame_time_i}));
      -2'sd1:  mydt = -RW'($signed({1'b0, frame_time_i}));
      -2'sd2:  mydt = -(RW'($signed({1'b0, frame_time_i})) <<< 1);
      default: mydt = '0;
    endcase
    yaw_t    = wrap360(RW'(yaw_q) - (RW'(move_x_i) <<< (FRAC_BITS - 2)));
    pitch_t  = wrap360(RW'(pitch_q) + rescale16(mydt * RW'(-75)) + D180) - D180;
    height_t = 34'(height_q) + 34'(rescale16(mydt * RW'(30)));
    yaw_d    = AW'(yaw_t);
    pitch_d  = AW'(pitch_t);
    height_d = ocvm_pkg::sat32(SAT_W'(height_t));
  end

  // cordic load, step and result
  logic signed [RW-1:0] ang;
  logic signed [ZW-1:0] atan_s;
  logic signed [TW-1:0] xsh, ysh, cres_x, cres_y;
  always_comb begin
    if (cmd_i.op == ocvm_pkg::OP_CLOAD_YAW) begin
      ang = RW'(yaw_q);
    end else if (pitch_q < 0) begin
      ang = RW'(pitch_q) + D360;
    end else begin
      ang = RW'(pitch_q);
    end
    atan_s = $signed(ZW'(ocvm_pkg::atan_fix(cmd_i.iter, FRAC_BITS)));
    xsh    = cdx_q >>> cmd_i.iter;
    ysh    = cdy_q >>> cmd_i.iter;
    cres_x = flip_q ? -cdx_q : cdx_q;
    cres_y = flip_q ? -cdy_q : cdy_q;
  end

  // row entries in Q4.30, picked by row
  logic signed [TW-1:0] rx, ry, rz;
  always_comb begin
    case (cmd_i.row)
      2'd0: begin
        rx = pneg_q ? -ysin_q : ysin_q;
        ry = '0;
        rz = pneg_q ? ycos_q : -ycos_q;
      end
      2'd1: begin
        rx = pneg_q ? -mcysp_q : mcysp_q;
        ry = pneg_q ? -pcos_q : pcos_q;
        rz = pneg_q ? -msysp_q : msysp_q;
      end
      default: begin
        rx = mcycp_q;
        ry = -psin_q;
        rz = msycp_q;
      end
    endcase
  end

  // shared multiplier operands
  logic signed [MW-1:0] op_a, op_b;
  logic signed [PW-1:0] prod_d;
  logic signed [TW-1:0] qres;
  always_comb begin
    case (cmd_i.msel)
      ocvm_pkg::M_CYSP:  begin op_a = ycos_q; op_b = psin_q; end
      ocvm_pkg::M_SYSP:  begin op_a = ysin_q; op_b = psin_q; end
      ocvm_pkg::M_CYCP:  begin op_a = ycos_q; op_b = pcos_q; end
      ocvm_pkg::M_SYCP:  begin op_a = ysin_q; op_b = pcos_q; end
      ocvm_pkg::M_CYRAD: begin op_a = ycos_q; op_b = $signed(MW'(radius_q)); end
      ocvm_pkg::M_SYRAD: begin op_a = ysin_q; op_b = $signed(MW'(radius_q)); end
      ocvm_pkg::M_TX:    begin op_a = rx;     op_b = eye_x_q; end
      ocvm_pkg::M_TY:    begin op_a = ry;     op_b = MW'(height_q); end
      ocvm_pkg::M_TZ:    begin op_a = rz;     op_b = eye_z_q; end
      default:           begin op_a = '0;     op_b = '0; end
    endcase
    prod_d = op_a * op_b;
    qres   = TW'((prod_q + QRND) >>> ocvm_pkg::TRIG_BITS);
  end

  // output row rounding
  logic signed [TW:0]     ex_r, ey_r, ez_r;
  logic signed [ACC_W-1:0] tr_r;
  always_comb begin
    ex_r = ((TW+1)'(rx) + ERND) >>> ESH;
    ey_r = ((TW+1)'(ry) + ERND) >>> ESH;
    ez_r = ((TW+1)'(rz) + ERND) >>> ESH;
    tr_r = (TRND - acc_q) >>> ocvm_pkg::TRIG_BITS;
  end

  assign out_free_o = !row_valid_q || row_ready_i;
  assign row_valid_o = row_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= 31'd655360;
      yaw_q       <= '0;
      pitch_q     <= -AW'(longint'(12) << FRAC_BITS);
      height_q    <= '0;
      pend_q      <= 1'b0;
      row_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        radius_q <= cfg_wdata_i;
      end
      if (cmd_i.take && move_valid_i) begin
        yaw_q    <= yaw_d;
        pitch_q  <= pitch_d;
        height_q <= height_d;
      end
      pend_q <= (cmd_i.op == ocvm_pkg::OP_MUL);
      if (cmd_i.op == ocvm_pkg::OP_EMIT) begin
        row_valid_q <= 1'b1;
      end else if (row_ready_i) begin
        row_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ocvm_pkg::OP_CLOAD_YAW,
      ocvm_pkg::OP_CLOAD_PITCH: begin
        cdx_q <= ocvm_pkg::CORDIC_GAIN;
        cdy_q <= '0;
        if (ang <= D90) begin
          cdz_q  <= ZW'(ang);
          flip_q <= 1'b0;
        end else if (ang < D270) begin
          cdz_q  <= ZW'(ang - D180);
          flip_q <= 1'b1;
        end else begin
          cdz_q  <= ZW'(ang - D360);
          flip_q <= 1'b0;
        end
      end
      ocvm_pkg::OP_CITER: begin
        if (cdz_q >= 0) begin
          cdx_q <= cdx_q - ysh;
          cdy_q <= cdy_q + xsh;
          cdz_q <= cdz_q - atan_s;
        end else begin
          cdx_q <= cdx_q + ysh;
          cdy_q <= cdy_q - xsh;
          cdz_q <= cdz_q + atan_s;
        end
      end
      ocvm_pkg::OP_CSTORE_YAW: begin
        ycos_q <= cres_x;
        ysin_q <= cres_y;
      end
      ocvm_pkg::OP_CSTORE_PITCH: begin
        pcos_q <= cres_x;
        psin_q <= cres_y;
        pneg_q <= cres_x < 0;
      end
      ocvm_pkg::OP_MUL: begin
        prod_q <= prod_d;
        psel_q <= cmd_i.msel;
      end
      ocvm_pkg::OP_EMIT: begin
        row_index_o         <= cmd_i.row;
        entry_x_o           <= ocvm_pkg::sat32(SAT_W'(ex_r));
        entry_y_o           <= ocvm_pkg::sat32(SAT_W'(ey_r));
        entry_z_o           <= ocvm_pkg::sat32(SAT_W'(ez_r));
        entry_translation_o <= ocvm_pkg::sat32(SAT_W'(tr_r));
        last_row_o          <= (cmd_i.row == 2'd2);
      end
      default: ;
    endcase
    // product commit, in the cycle after issue
    if (pend_q) begin
      case (psel_q)
        ocvm_pkg::M_CYSP:  mcysp_q <= qres;
        ocvm_pkg::M_SYSP:  msysp_q <= qres;
        ocvm_pkg::M_CYCP:  mcycp_q <= qres;
        ocvm_pkg::M_SYCP:  msycp_q <= qres;
        ocvm_pkg::M_CYRAD: eye_x_q <= qres;
        ocvm_pkg::M_SYRAD: eye_z_q <= qres;
        ocvm_pkg::M_TX:    acc_q   <= ACC_W'(prod_q);
        ocvm_pkg::M_TY,
        ocvm_pkg::M_TZ:    acc_q   <= acc_q + ACC_W'(prod_q);
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/orbit_camera_view_matrix.sv =====
// orbit_camera_view_matrix: top level, joins the sequencer and the datapath
// depends on ocvm_pkg, ocvm_frame_if, ocvm_row_if, ocvm_ctrl, ocvm_datapath
//
//   channel   dir  handshake      carries
//   frame_i   in   valid/ready    move_valid, move_x, move_y, frame_time
//   row_o     out  valid/ready    row_index, entry_x/y/z, entry_translation, last_row
//   cfg       in   cfg_we_i       eye circle radius on cfg_wdata_i
//
// when rows drain freely, the time one frame item takes is set by the shared cordic, run
// once for yaw and once for pitch, and by the single multiplier that forms the six
// products and the three translation dots
// a new item is taken only when the previous one has left its last row in the output
// register; a stalled row holds the sequencer in place
// reset is asynchronous, active low, and restores the radius, yaw, pitch and height
module orbit_camera_view_matrix #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [30:0]  cfg_wdata_i,
  ocvm_frame_if.sink   frame_i,
  ocvm_row_if.source   row_o
);

  ocvm_pkg::cmd_t    cmd;
  ocvm_pkg::status_t status;
  logic              out_free;

  assign status.frame_valid = frame_i.valid;
  assign status.out_free    = out_free;
  assign frame_i.ready      = cmd.ready;

  ocvm_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  ocvm_datapath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .out_free_o          (out_free),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .move_valid_i        (frame_i.move_valid),
    .move_x_i            (frame_i.move_x),
    .move_y_i            (frame_i.move_y),
    .frame_time_i        (frame_i.frame_time),
    .row_ready_i         (row_o.ready),
    .row_valid_o         (row_o.valid),
    .row_index_o         (row_o.row_index),
    .entry_x_o           (row_o.entry_x),
    .entry_y_o           (row_o.entry_y),
    .entry_z_o           (row_o.entry_z),
    .entry_translation_o (row_o.entry_translation),
    .last_row_o          (row_o.last_row)
  );

endmodule

// ===== verif/orbit_camera_view_matrix_tb.sv =====
// orbit_camera_view_matrix_tb: self-checking testbench of the orbit camera view matrix
// predicts the three view rows of every frame item in fixed point and compares them
// depends on ocvm_frame_if, ocvm_row_if and orbit_camera_view_matrix
`timescale 1ns / 100ps

module orbit_camera_view_matrix_tb;

  localparam int  FRAC          = 16;
  localparam int  STEPS         = 16;
  localparam int  TRIG          = 30;
  localparam int  RANDOM_FRAMES = 420;
  localparam int  IDLE_LIMIT    = 2000;
  localparam int  HOLD_CYCLES   = 400;
  localparam int  DRAIN_CYCLES  = 80;
  localparam longint GAIN_Q30   = 64'sd652032874;

  typedef struct {
    logic [1:0]         idx;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] ez;
    logic signed [31:0] tr;
    logic               last;
    bit                 zero_tr;
  } view_row_t;

  typedef struct {
    bit          set_radius;
    logic [30:0] radius;
    logic        mv;
    logic [1:0]  mx;
    logic [1:0]  my;
    logic [15:0] dt;
    bit          zero_tr;
  } frame_stim_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [30:0] cfg_wdata_i = '0;

  ocvm_frame_if frame_if ();
  ocvm_row_if   row_if ();

  orbit_camera_view_matrix dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .frame_i     (frame_if.sink),
    .row_o       (row_if.source)
  );

  always #1 clk_i = ~clk_i;

  // camera state as the block should hold it
  logic [30:0] radius_q;
  longint      yaw_q;
  longint      pitch_q;
  longint      height_q;
  view_row_t   pending_rows[$];
  int          errors;
  int          rows_seen;
  int          idle_cycles;
  bit          rx_calm;

  localparam longint ATAN_Q24[24] = '{
    754974720, 445687602, 235489088, 119537938, 60000935, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234683, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };

  function automatic longint round_shift(input longint v, input int d);
    if (d <= 0) begin
      return v;
    end
    return (v + (64'sd1 <<< (d - 1))) >>> d;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint wrap_deg(input longint a);
    longint full;
    longint r;
    full = 64'sd360 <<< FRAC;
    r = a % full;
    if (r < 0) begin
      r += full;
    end
    return r;
  endfunction

  function automatic longint mul_q30(input longint a, input longint b);
    return round_shift(a * b, TRIG);
  endfunction

  function automatic void sin_cos(input longint ang, output longint c, output longint s);
    longint quarter, a, x, y, z, nx, step;
    bit flip;
    quarter = 64'sd90 <<< FRAC;
    a = wrap_deg(ang);
    x = GAIN_Q30;
    y = 0;
    flip = 1'b0;
    if (a <= quarter) begin
      z = a;
    end else if (a < 3 * quarter) begin
      z = a - 2 * quarter;
      flip = 1'b1;
    end else begin
      z = a - 4 * quarter;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      step = round_shift(ATAN_Q24[i], 24 - FRAC);
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= step;
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += step;
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // applies the movement and queues the three rows the frame should produce
  function automatic void predict_view_rows(input frame_stim_t f);
    longint half, mx, my, dt, cy, sy, cp, sp, sg, ex, ey, ez, rad, t;
    longint m[3][3];
    view_row_t r;
    half = 64'sd180 <<< FRAC;
    if (f.mv) begin
      mx = longint'($signed(f.mx));
      my = longint'($signed(f.my));
      dt = longint'(f.dt);
      yaw_q    = wrap_deg(yaw_q - mx * (64'sd1 <<< (FRAC - 2)));
      pitch_q  = wrap_deg(pitch_q + round_shift(-75 * my * dt, 16 - FRAC) + half) - half;
      height_q = clamp32(height_q + round_shift(30 * my * dt, 16 - FRAC));
    end
    sin_cos(yaw_q, cy, sy);
    sin_cos(pitch_q, cp, sp);
    sg = (cp < 0) ? -1 : 1;
    m[0][0] = sg * sy;
    m[0][1] = 0;
    m[0][2] = -sg * cy;
    m[1][0] = sg * mul_q30(cy, sp);
    m[1][1] = sg * cp;
    m[1][2] = sg * mul_q30(sy, sp);
    m[2][0] = mul_q30(cy, cp);
    m[2][1] = -sp;
    m[2][2] = mul_q30(sy, cp);
    rad = longint'(radius_q);
    ex = round_shift(cy * rad, TRIG);
    ey = height_q;
    ez = round_shift(sy * rad, TRIG);
    for (int k = 0; k < 3; k++) begin
      t = -(m[k][0] * ex + m[k][1] * ey + m[k][2] * ez);
      r.idx     = 2'(k);
      r.ex      = 32'(clamp32(round_shift(m[k][0], TRIG - FRAC)));
      r.ey      = 32'(clamp32(round_shift(m[k][1], TRIG - FRAC)));
      r.ez      = 32'(clamp32(round_shift(m[k][2], TRIG - FRAC)));
      r.tr      = 32'(clamp32(round_shift(t, TRIG)));
      r.last    = (k == 2);
      r.zero_tr = f.zero_tr;
      pending_rows.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("row %0d: %s got %0d expected %0d", rows_seen, what, got, want);
    errors++;
  endtask

  task automatic write_radius(input logic [30:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    radius_q = value;
  endtask

  task automatic wait_quiet();
    while (pending_rows.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send_frame(input frame_stim_t f, input int gap);
    if (f.set_radius) begin
      frame_if.valid <= 1'b0;
      wait_quiet();
      write_radius(f.radius);
    end else if (gap > 0) begin
      frame_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    frame_if.valid      <= 1'b1;
    frame_if.move_valid <= f.mv;
    frame_if.move_x     <= f.mx;
    frame_if.move_y     <= f.my;
    frame_if.frame_time <= f.dt;
    do @(posedge clk_i); while (!frame_if.ready);
    predict_view_rows(f);
  endtask

  function automatic frame_stim_t make_frame(input bit mv, input logic [1:0] mx,
                                             input logic [1:0] my, input logic [15:0] dt);
    frame_stim_t f;
    f = '{default: '0};
    f.mv = mv;
    f.mx = mx;
    f.my = my;
    f.dt = dt;
    return f;
  endfunction

  // row receiver with random stalls and one long hold-off
  initial begin
    int stall;
    bit held;
    row_if.ready = 1'b0;
    rx_calm = 1'b0;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 19) == 0) begin
        rx_calm = ~rx_calm;
      end
      stall = rx_calm ? 0 : $urandom_range(0, 17);
      if (!held && rows_seen == 90) begin
        held = 1'b1;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        row_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      row_if.ready <= 1'b1;
      do @(posedge clk_i); while (!row_if.valid);
      if (pending_rows.size() == 0) begin
        $display("row %0d: item with no frame outstanding", rows_seen);
        errors++;
      end else begin
        view_row_t w;
        w = pending_rows.pop_front();
        if (row_if.row_index !== w.idx) report_mismatch("row_index", row_if.row_index, w.idx);
        if (row_if.entry_x !== w.ex) report_mismatch("entry_x", row_if.entry_x, w.ex);
        if (row_if.entry_y !== w.ey) report_mismatch("entry_y", row_if.entry_y, w.ey);
        if (row_if.entry_z !== w.ez) report_mismatch("entry_z", row_if.entry_z, w.ez);
        if (row_if.entry_translation !== w.tr) begin
          report_mismatch("entry_translation", row_if.entry_translation, w.tr);
        end
        if (w.zero_tr && row_if.entry_translation !== 32'sd0) begin
          report_mismatch("translation at zero radius", row_if.entry_translation, 0);
        end
        if (row_if.last_row !== w.last) report_mismatch("last_row", row_if.last_row, w.last);
      end
      rows_seen++;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((frame_if.valid && frame_if.ready) || (row_if.valid && row_if.ready) || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    frame_stim_t table_rows[$];
    frame_stim_t f;
    bit tx_calm;
    int gap;
    int drift;
    logic [1:0] drift_y;

    frame_if.valid      = 1'b0;
    frame_if.move_valid = 1'b0;
    frame_if.move_x     = '0;
    frame_if.move_y     = '0;
    frame_if.frame_time = '0;
    errors      = 0;
    rows_seen   = 0;
    idle_cycles = 0;
    radius_q    = 31'd655360;
    yaw_q       = 0;
    pitch_q     = -(64'sd12 <<< FRAC);
    height_q    = 0;

    // directed frames; zero radius with untouched height gives zero translation
    table_rows.push_back(make_frame(1'b0, 2'b00, 2'b00, 16'h0000));
    table_rows.push_back(make_frame(1'b0, 2'b01, 2'b01, 16'hffff));
    f = make_frame(1'b1, 2'b01, 2'b00, 16'hffff);
    f.set_radius = 1'b1;
    f.radius = 31'd0;
    f.zero_tr = 1'b1;
    table_rows.push_back(f);
    f = make_frame(1'b1, 2'b11, 2'b00, 16'h0000);
    f.zero_tr = 1'b1;
    table_rows.push_back(f);
    f = make_frame(1'b1, 2'b10, 2'b00, 16'h1234);
    f.zero_tr = 1'b1;
    table_rows.push_back(f);
    f = make_frame(1'b0, 2'b10, 2'b10, 16'hffff);
    f.zero_tr = 1'b1;
    table_rows.push_back(f);
    f = make_frame(1'b1, 2'b00, 2'b01, 16'h0000);
    f.set_radius = 1'b1;
    f.radius = 31'h7fffffff;
    table_rows.push_back(f);
    table_rows.push_back(make_frame(1'b1, 2'b00, 2'b01, 16'hffff));
    table_rows.push_back(make_frame(1'b1, 2'b00, 2'b11, 16'hffff));
    // large pitch steps wrap past +-180 and turn cos(pitch) negative
    for (int i = 0; i < 4; i++) begin
      table_rows.push_back(make_frame(1'b1, 2'b01, 2'b10, 16'hffff));
    end
    table_rows.push_back(make_frame(1'b1, 2'b10, 2'b01, 16'h0001));
    table_rows.push_back(make_frame(1'b1, 2'b01, 2'b11, 16'h8000));
    // tiny radius with mixed pitch steps in both directions
    f = make_frame(1'b1, 2'b00, 2'b00, 16'h0000);
    f.set_radius = 1'b1;
    f.radius = 31'd1;
    table_rows.push_back(f);
    table_rows.push_back(make_frame(1'b1, 2'b00, 2'b01, 16'hffff));
    table_rows.push_back(make_frame(1'b1, 2'b00, 2'b11, 16'h5555));
    table_rows.push_back(make_frame(1'b1, 2'b11, 2'b10, 16'h7fff));
    table_rows.push_back(make_frame(1'b1, 2'b00, 2'b00, 16'hffff));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i]) begin
      send_frame(table_rows[i], $urandom_range(0, 3));
    end

    tx_calm = 1'b0;
    drift = 0;
    drift_y = 2'b01;
    for (int n = 0; n < RANDOM_FRAMES; n++) begin
      f = '{default: '0};
      if (n % 70 == 0) begin
        f.set_radius = 1'b1;
        case ($urandom_range(0, 3))
          0: f.radius = 31'd0;
          1: f.radius = 31'h7fffffff;
          2: f.radius = 31'($urandom_range(0, 32'h00ff_ffff));
          default: f.radius = 31'($urandom());
        endcase
      end
      // mostly held keys over several frames, some random noise
      if (drift == 0) begin
        drift = $urandom_range(1, 12);
        drift_y = 2'($urandom_range(0, 3));
      end
      drift--;
      f.mv = ($urandom_range(0, 7) != 0);
      f.my = ($urandom_range(0, 3) != 0) ? drift_y : 2'($urandom_range(0, 3));
      f.mx = 2'($urandom_range(0, 3));
      f.dt = ($urandom_range(0, 9) == 0) ? 16'hffff : 16'($urandom());
      if ($urandom_range(0, 15) == 0) begin
        tx_calm = ~tx_calm;
      end
      gap = tx_calm ? 0 : $urandom_range(0, 17);
      send_frame(f, gap);
    end
    frame_if.valid <= 1'b0;

    while (pending_rows.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
